[src/nbg_pkg.sv]
package nbg_pkg;

  // Body storage size; a step uses at most 64 bodies.
  localparam int BODIES  = 64;
  localparam int NMAX    = (BODIES < 64) ? BODIES : 64;
  localparam int IDX_W   = $clog2(BODIES);
  localparam int ADDR3_W = $clog2(BODIES * 3);

  // Input item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_GRAVITY   = 2'd0,
    CFG_TIME_STEP = 2'd1,
    CFG_ACTIVE    = 2'd2
  } cfg_reg_t;

  // Saturation limits
  localparam logic [45:0] S_CAP = {46{1'b1}};
  localparam logic [48:0] C_CAP = 49'h1_0000_0000_0000;
  localparam logic [46:0] E_CAP = {47{1'b1}};
  localparam logic [47:0] P_CAP = 48'h8000_0000_0000;
  localparam logic signed [51:0] A_MAX = 52'sh0_1000_0000_0000;
  localparam logic signed [51:0] A_MIN = -52'sh0_1000_0000_0000;

  // Divide / root unit handshake
  typedef struct packed {
    logic start;
    logic root;
  } ds_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -52'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Word address of axis k of a body
  function automatic logic [ADDR3_W-1:0] body_addr(input logic [5:0] idx,
                                                    input logic [1:0] k);
    return ADDR3_W'(int'(idx) * 3 + int'(k));
  endfunction

endpackage

[src/nbg_in_if.sv]
interface nbg_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [5:0]         body_index;
  logic signed [31:0] load_pos_x;
  logic signed [31:0] load_pos_y;
  logic signed [31:0] load_pos_z;
  logic signed [31:0] load_vel_x;
  logic signed [31:0] load_vel_y;
  logic signed [31:0] load_vel_z;
  logic [31:0]        load_mass;

  modport source (output valid, mode, body_index, load_pos_x, load_pos_y, load_pos_z,
                  load_vel_x, load_vel_y, load_vel_z, load_mass, input ready);
  modport sink (input valid, mode, body_index, load_pos_x, load_pos_y, load_pos_z,
                load_vel_x, load_vel_y, load_vel_z, load_mass, output ready);
endinterface

[src/nbg_out_if.sv]
interface nbg_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         out_index;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [47:0] body_energy;
  logic               last_body;

  modport source (output valid, out_index, out_pos_x, out_pos_y, out_pos_z, body_energy,
                  last_body, input ready);
  modport sink (input valid, out_index, out_pos_x, out_pos_y, out_pos_z, body_energy,
                last_body, output ready);
endinterface

[src/nbg_divsqrt.sv]
// Shared restoring divider (64 by 32 bits, one quotient bit a cycle) and
// integer square root (64 bits, one root bit a cycle).
module nbg_divsqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  nbg_pkg::ds_ctrl_t ctrl,
  input  logic [63:0]      num,
  input  logic [31:0]      den,
  output nbg_pkg::ds_stat_t stat,
  output logic [63:0]      q
);

  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] ROOT_STEPS = 7'd32;

  logic        busy_r;
  logic        done_r;
  logic        root_r;
  logic [6:0]  cnt_r;
  logic [63:0] x_r;
  logic [34:0] rem_r;
  logic [31:0] den_r;
  logic [63:0] q_r;

  logic [34:0] rsh;
  logic [34:0] trial;
  logic        ge;
  logic [34:0] rem_nxt;

  // One trial subtract per cycle
  always_comb begin
    if (root_r) begin
      rsh   = {rem_r[32:0], x_r[63:62]};
      trial = {1'b0, q_r[31:0], 2'b01};
    end else begin
      rsh   = {rem_r[33:0], x_r[63]};
      trial = {3'b000, den_r};
    end
    ge      = (rsh >= trial);
    rem_nxt = ge ? (rsh - trial) : rsh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        root_r <= ctrl.root;
        cnt_r  <= ctrl.root ? ROOT_STEPS : DIV_STEPS;
        x_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[62:0], ge};
        x_r   <= root_r ? {x_r[61:0], 2'b00} : {x_r[62:0], 1'b0};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign q         = q_r;

endmodule

[src/n_body_gravity_step.sv]
// Channel  Dir  Payload                                              Transfer
// in_chan  in   mode, body_index, load_pos_*, load_vel_*, load_mass  valid & ready
// out_chan out  out_index, out_pos_*, body_energy, last_body         valid & ready
// cfg_*    in   cfg_index, cfg_data                                  cfg_we
//
// A load writes the position and velocity of one body, axis by axis. For n active
// bodies, each body pair with a massive partner at nonzero distance runs one root and
// seven divides through the shared one-bit-a-cycle divide/root unit.
// Reset (rst_n low, synchronous) clears control; the body stores are not cleared.
// A result waits in the output register; the sequencer stalls only when a
// second result is ready before the first was taken.
module n_body_gravity_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  nbg_in_if.sink      in_chan,
  nbg_out_if.source   out_chan
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_BODY, S_BODY_RD, S_PAIR, S_PAIR_RD, S_R2, S_R2END, S_R2CHK,
    S_SQRT, S_SDIV, S_SDIV_W, S_U, S_U_W, S_WM0, S_WM1, S_WM2, S_C, S_C_W, S_POT,
    S_UPD, S_UPD1, S_UPD2, S_UPD3, S_UPD4, S_KIN, S_EMIT
  } state_t;

  // Configuration
  logic [31:0] g_r;
  logic [31:0] dt_r;
  logic [6:0]  act_r;

  // Sequencer
  state_t      st_r;
  state_t      ret_r;
  logic [1:0]  k_r;
  logic [6:0]  i_r;
  logic [6:0]  j_r;
  logic [6:0]  n_r;

  // Load item
  logic               ld_ok_r;
  logic [5:0]         ld_idx_r;
  logic signed [31:0] ld_pos_r [3];
  logic signed [31:0] ld_vel_r [3];
  logic [31:0]        ld_mass_r;

  // Datapath
  logic [31:0]        mi_r;
  logic [31:0]        mj_r;
  logic signed [31:0] pi_r [3];
  logic signed [31:0] d_r [3];
  logic [63:0]        r2_r;
  logic [31:0]        r_r;
  logic [45:0]        s_r;
  logic signed [49:0] acc_r [3];
  logic [47:0]        pot_r;
  logic [63:0]        vsq_r;
  logic signed [31:0] vn_r;
  logic signed [31:0] pn_r [3];
  logic [47:0]        wa_r;
  logic [31:0]        wb_r;
  logic [79:0]        wp_r;
  logic [63:0]        mp_r;

  // Output register
  logic               out_valid_r;
  logic [5:0]         out_index_r;
  logic signed [31:0] out_pos_r [3];
  logic signed [47:0] out_energy_r;
  logic               out_last_r;

  // Memories
  logic signed [31:0] pos_mem  [nbg_pkg::BODIES * 3];
  logic signed [31:0] vel_mem  [nbg_pkg::BODIES * 3];
  logic [31:0]        mass_mem [nbg_pkg::BODIES];
  logic signed [31:0] pos_q_r;
  logic signed [31:0] vel_q_r;
  logic [31:0]        mass_q_r;

  logic [nbg_pkg::ADDR3_W-1:0] pos_ra, pos_wa, vel_ra, vel_wa;
  logic [nbg_pkg::IDX_W-1:0]   mass_ra, mass_wa;
  logic                        pos_we, vel_we, mass_we;
  logic signed [31:0]          pos_wd, vel_wd;

  // Shared multiplier and divide/root unit
  logic [31:0]       ma, mb;
  nbg_pkg::ds_ctrl_t ds_ctrl;
  nbg_pkg::ds_stat_t ds_stat;
  logic [63:0]       ds_num;
  logic [63:0]       ds_q;

  // Combinational helpers
  logic [1:0]         k_next;
  logic signed [31:0] d_new;
  logic signed [31:0] a_k;
  logic signed [31:0] v_new;
  logic signed [31:0] p_new;
  logic [48:0]        c_val;
  logic signed [51:0] acc_sum;
  logic [46:0]        term;
  logic [48:0]        pot_sum;
  logic [63:0]        vsq_sum;
  logic               out_free;
  logic [6:0]         n_step;

  nbg_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ds_ctrl),
    .num   (ds_num),
    .den   (r_r),
    .stat  (ds_stat),
    .q     (ds_q)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r   <= 32'd65536;
      dt_r  <= 32'd65536;
      act_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nbg_pkg::CFG_GRAVITY:   g_r   <= cfg_data;
        nbg_pkg::CFG_TIME_STEP: dt_r  <= cfg_data;
        nbg_pkg::CFG_ACTIVE:    act_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (vel_we) vel_mem[vel_wa] <= vel_wd;
    if (mass_we) mass_mem[mass_wa] <= ld_mass_r;
    pos_q_r  <= pos_mem[pos_ra];
    vel_q_r  <= vel_mem[vel_ra];
    mass_q_r <= mass_mem[mass_ra];
  end

  // Multiplier with registered product
  always_ff @(posedge clk) begin
    mp_r <= ma * mb;
  end

  // Datapath arithmetic
  always_comb begin
    k_next  = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
    d_new   = nbg_pkg::sat32(52'(pos_q_r) - 52'(pi_r[k_r]));
    a_k     = nbg_pkg::sat32(52'(acc_r[k_r]));
    v_new   = nbg_pkg::sat32(52'(vel_q_r) + (a_k[31] ? -$signed({4'b0, mp_r[63:16]})
                                                      : $signed({4'b0, mp_r[63:16]})));
    p_new   = nbg_pkg::sat32(52'(pi_r[k_r]) + (vn_r[31] ? -$signed({4'b0, mp_r[63:16]})
                                                         : $signed({4'b0, mp_r[63:16]})));
    c_val   = (ds_q > 64'(nbg_pkg::C_CAP)) ? nbg_pkg::C_CAP : ds_q[48:0];
    acc_sum = 52'(acc_r[k_r]) + (d_r[k_r][31] ? -$signed({3'b0, c_val})
                                              : $signed({3'b0, c_val}));
    term    = (wp_r[79:17] > 63'(nbg_pkg::E_CAP)) ? nbg_pkg::E_CAP : wp_r[63:17];
    pot_sum = 49'(pot_r) + 49'(term);
    vsq_sum = vsq_r + mp_r;
    out_free = !out_valid_r || out_chan.ready;
    n_step  = (int'(act_r) > nbg_pkg::NMAX) ? 7'(nbg_pkg::NMAX) : act_r;
  end

  // Operand, address and unit control selection
  always_comb begin
    ma      = '0;
    mb      = '0;
    pos_ra  = '0;
    vel_ra  = '0;
    mass_ra = '0;
    pos_we  = 1'b0;
    vel_we  = 1'b0;
    mass_we = 1'b0;
    pos_wa  = nbg_pkg::body_addr(i_r[5:0], k_r);
    vel_wa  = nbg_pkg::body_addr(i_r[5:0], k_r);
    mass_wa = nbg_pkg::IDX_W'(ld_idx_r);
    pos_wd  = p_new;
    vel_wd  = v_new;
    ds_ctrl = '0;
    ds_num  = '0;
    unique case (st_r)
      S_LOAD: begin
        pos_we  = ld_ok_r;
        vel_we  = ld_ok_r;
        mass_we = ld_ok_r && (k_r == 2'd0);
        pos_wa  = nbg_pkg::body_addr(ld_idx_r, k_r);
        vel_wa  = nbg_pkg::body_addr(ld_idx_r, k_r);
        pos_wd  = ld_pos_r[k_r];
        vel_wd  = ld_vel_r[k_r];
      end
      S_BODY: begin
        mass_ra = nbg_pkg::IDX_W'(i_r[5:0]);
        pos_ra  = nbg_pkg::body_addr(i_r[5:0], 2'd0);
      end
      S_BODY_RD: pos_ra = nbg_pkg::body_addr(i_r[5:0], k_next);
      S_PAIR: begin
        mass_ra = nbg_pkg::IDX_W'(j_r[5:0]);
        pos_ra  = nbg_pkg::body_addr(j_r[5:0], 2'd0);
      end
      S_PAIR_RD: pos_ra = nbg_pkg::body_addr(j_r[5:0], k_next);
      S_R2: begin
        ma = nbg_pkg::mag32(d_r[k_r]);
        mb = nbg_pkg::mag32(d_r[k_r]);
      end
      S_R2CHK: begin
        ds_ctrl.start = (r2_r != '0);
        ds_ctrl.root  = 1'b1;
        ds_num        = r2_r;
      end
      S_SQRT, S_SDIV_W: begin
        ma = g_r;
        mb = mj_r;
      end
      S_SDIV: begin
        ma            = g_r;
        mb            = mj_r;
        ds_ctrl.start = 1'b1;
        ds_num        = mp_r;
      end
      S_U: begin
        ds_ctrl.start = 1'b1;
        ds_num        = {16'b0, nbg_pkg::mag32(d_r[k_r]), 16'b0};
      end
      S_WM0: begin
        ma = wa_r[31:0];
        mb = wb_r;
      end
      S_WM1: begin
        ma = 32'(wa_r[47:32]);
        mb = wb_r;
      end
      S_C: begin
        ds_ctrl.start = 1'b1;
        ds_num        = wp_r[63:0];
      end
      S_UPD: begin
        vel_ra = nbg_pkg::body_addr(i_r[5:0], k_r);
        ma     = nbg_pkg::mag32(a_k);
        mb     = dt_r;
      end
      S_UPD1: vel_we = 1'b1;
      S_UPD2: begin
        ma = nbg_pkg::mag32(vn_r);
        mb = dt_r;
      end
      S_UPD3: begin
        pos_we = 1'b1;
        ma     = nbg_pkg::mag32(vn_r);
        mb     = nbg_pkg::mag32(vn_r);
      end
      default: ;
    endcase
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ret_r       <= S_IDLE;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once transferred, unless a new one replaces it
      if (out_valid_r && out_chan.ready && st_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (st_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            if (in_chan.mode == nbg_pkg::MODE_LOAD) begin
              ld_ok_r     <= int'(in_chan.body_index) < nbg_pkg::BODIES;
              ld_idx_r    <= in_chan.body_index;
              ld_pos_r[0] <= in_chan.load_pos_x;
              ld_pos_r[1] <= in_chan.load_pos_y;
              ld_pos_r[2] <= in_chan.load_pos_z;
              ld_vel_r[0] <= in_chan.load_vel_x;
              ld_vel_r[1] <= in_chan.load_vel_y;
              ld_vel_r[2] <= in_chan.load_vel_z;
              ld_mass_r   <= in_chan.load_mass;
              k_r         <= '0;
              st_r        <= S_LOAD;
            end else begin
              n_r  <= n_step;
              i_r  <= '0;
              st_r <= S_BODY;
            end
          end
        end
        S_LOAD: begin
          if (k_r == 2'd2) begin
            k_r  <= '0;
            st_r <= S_IDLE;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_BODY: begin
          k_r  <= '0;
          st_r <= (i_r == n_r) ? S_IDLE : S_BODY_RD;
        end
        S_BODY_RD: begin
          pi_r[k_r] <= pos_q_r;
          if (k_r == 2'd0) mi_r <= mass_q_r;
          if (k_r == 2'd2) begin
            for (int a = 0; a < 3; a++) acc_r[a] <= '0;
            pot_r <= '0;
            vsq_r <= '0;
            j_r   <= '0;
            k_r   <= '0;
            st_r  <= S_PAIR;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_PAIR: begin
          k_r <= '0;
          if (j_r == n_r) begin
            st_r <= S_UPD;
          end else if (j_r == i_r) begin
            j_r <= j_r + 7'd1;
          end else begin
            st_r <= S_PAIR_RD;
          end
        end
        S_PAIR_RD: begin
          if (k_r == 2'd0 && mass_q_r == '0) begin
            // massless partner: no pull
            j_r  <= j_r + 7'd1;
            st_r <= S_PAIR;
          end else begin
            d_r[k_r] <= d_new;
            if (k_r == 2'd0) mj_r <= mass_q_r;
            if (k_r == 2'd2) begin
              k_r  <= '0;
              r2_r <= '0;
              st_r <= S_R2;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        S_R2: begin
          if (k_r != 2'd0) r2_r <= r2_r + mp_r;
          if (k_r == 2'd2) begin
            k_r  <= '0;
            st_r <= S_R2END;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_R2END: begin
          r2_r <= r2_r + mp_r;
          st_r <= S_R2CHK;
        end
        S_R2CHK: begin
          // skip a pair at zero distance
          if (r2_r == '0) begin
            j_r  <= j_r + 7'd1;
            st_r <= S_PAIR;
          end else begin
            st_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ds_stat.done) begin
            r_r  <= ds_q[31:0];
            st_r <= S_SDIV;
          end
        end
        S_SDIV: st_r <= S_SDIV_W;
        S_SDIV_W: begin
          if (ds_stat.done) begin
            s_r  <= (ds_q > 64'(nbg_pkg::S_CAP)) ? nbg_pkg::S_CAP : ds_q[45:0];
            k_r  <= '0;
            st_r <= S_U;
          end
        end
        S_U: st_r <= S_U_W;
        S_U_W: begin
          if (ds_stat.done) begin
            wa_r  <= 48'(s_r);
            wb_r  <= 32'(ds_q[16:0]);
            ret_r <= S_C;
            st_r  <= S_WM0;
          end
        end
        S_WM0: st_r <= S_WM1;
        S_WM1: begin
          wp_r <= 80'(mp_r);
          st_r <= S_WM2;
        end
        S_WM2: begin
          wp_r <= wp_r + {mp_r[47:0], 32'b0};
          st_r <= ret_r;
        end
        S_C: st_r <= S_C_W;
        S_C_W: begin
          if (ds_stat.done) begin
            if (acc_sum > nbg_pkg::A_MAX) acc_r[k_r] <= 50'(nbg_pkg::A_MAX);
            else if (acc_sum < nbg_pkg::A_MIN) acc_r[k_r] <= 50'(nbg_pkg::A_MIN);
            else acc_r[k_r] <= 50'(acc_sum);
            if (k_r == 2'd2) begin
              k_r   <= '0;
              wa_r  <= 48'(s_r);
              wb_r  <= mi_r;
              ret_r <= S_POT;
              st_r  <= S_WM0;
            end else begin
              k_r  <= k_r + 2'd1;
              st_r <= S_U;
            end
          end
        end
        S_POT: begin
          pot_r <= (pot_sum > 49'(nbg_pkg::P_CAP)) ? nbg_pkg::P_CAP : pot_sum[47:0];
          j_r   <= j_r + 7'd1;
          st_r  <= S_PAIR;
        end
        S_UPD: st_r <= S_UPD1;
        S_UPD1: begin
          vn_r <= v_new;
          st_r <= S_UPD2;
        end
        S_UPD2: st_r <= S_UPD3;
        S_UPD3: begin
          pn_r[k_r] <= p_new;
          st_r      <= S_UPD4;
        end
        S_UPD4: begin
          vsq_r <= vsq_sum;
          if (k_r == 2'd2) begin
            k_r   <= '0;
            wa_r  <= vsq_sum[63:16];
            wb_r  <= mi_r;
            ret_r <= S_KIN;
            st_r  <= S_WM0;
          end else begin
            k_r  <= k_r + 2'd1;
            st_r <= S_UPD;
          end
        end
        S_KIN: begin
          out_energy_r <= $signed(48'(term) - pot_r);
          st_r         <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_index_r  <= i_r[5:0];
            out_pos_r[0] <= pn_r[0];
            out_pos_r[1] <= pn_r[1];
            out_pos_r[2] <= pn_r[2];
            out_last_r   <= (i_r + 7'd1) == n_r;
            i_r          <= i_r + 7'd1;
            st_r         <= S_BODY;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready        = (st_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_index   = out_index_r;
  assign out_chan.out_pos_x   = out_pos_r[0];
  assign out_chan.out_pos_y   = out_pos_r[1];
  assign out_chan.out_pos_z   = out_pos_r[2];
  assign out_chan.body_energy = out_energy_r;
  assign out_chan.last_body   = out_last_r;

  // Start the shared unit only when it is free
  a_ds_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    ds_ctrl.start |-> !ds_stat.busy)
    else $error("divide/root unit started while busy");

  // No new item while the shared unit works
  a_ready_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    ds_stat.busy |-> !in_chan.ready)
    else $error("input ready while divide/root unit busy");

  // Body counter stays within the step
  a_body_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE && st_r != S_LOAD) |-> (i_r <= n_r))
    else $error("body counter past active count");

endmodule
